[sv/els_pkg.sv]
// ---------------------------------------------------------------------------
// els_pkg
// Shared widths, constants and register codes of the echo level smoother.
// ---------------------------------------------------------------------------
`default_nettype none

package els_pkg;

	// field widths
	localparam int WIDTH_W = 19;
	localparam int DIST_W  = 16;
	localparam int PCT_W   = 7;

	// echo time to distance: microseconds per cm, out and back
	localparam int US_PER_CM  = 29;
	localparam int ROUND_TRIP = 2;
	localparam int ECHO_DIV   = US_PER_CM * ROUND_TRIP;

	// percent scale
	localparam int PCT_FULL = 100;

	// scaled numerator (distance offset times 100) width
	localparam int NUM_W = DIST_W + PCT_W;

	// ring depth default
	localparam int NUM_SAMPLES_DEF = 8;

	// configuration registers
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY = 1'd1;

	localparam logic [DIST_W-1:0] FULL_RESET  = 16'd255;
	localparam logic [DIST_W-1:0] EMPTY_RESET = 16'd0;

	// update modes
	localparam logic OP_NORMAL = 1'b0;
	localparam logic OP_FAST   = 1'b1;

endpackage

`default_nettype wire

[sv/echo_level_percent_smoother.sv]
// ---------------------------------------------------------------------------
// echo_level_percent_smoother
// Converts an echo width to a level percentage and keeps a moving average.
// ---------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  in       | in_valid / in_ready  | operation, echo_width_us
//  out      | out_valid/ out_ready | smoothed_percent, instant_percent
//  cfg      | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
//  One word at a time. A normal update runs the divide by 58, the clamp,
//  the scaling divide (skipped when full_distance >= empty_distance), the
//  ring write and the mean divide; a fast update fills the whole ring. The
//  divide by 58 is bit-serial; the two 7-step quotient loops share one divider.
//  After reset the ring reads as zero through per-entry valid bits.
//  The next word is taken while a finished result waits on out_ready.
//
`default_nettype none

module echo_level_percent_smoother #(
	parameter int NUM_SAMPLES = els_pkg::NUM_SAMPLES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input words
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          operation,
	input  wire logic [els_pkg::WIDTH_W-1:0]   echo_width_us,
	// result words
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [els_pkg::PCT_W-1:0]          smoothed_percent,
	output logic [els_pkg::PCT_W-1:0]          instant_percent,
	// configuration writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [els_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [els_pkg::DIST_W-1:0]    cfg_data
);
	import els_pkg::*;

	localparam int IDX_W  = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
	localparam int SUM_W  = $clog2(PCT_FULL * NUM_SAMPLES + 1);
	localparam int REM_W  = (SUM_W > NUM_W) ? SUM_W : NUM_W;
	localparam int CNT_W  = $clog2(WIDTH_W);
	localparam int STEP_W = $clog2(PCT_W);
	localparam int WREM_W = $clog2(ECHO_DIV);

	typedef enum logic [3:0] {
		S_IDLE, S_DIST, S_CLAMP, S_SCALE, S_PDIV,
		S_RING, S_FILL, S_MLOAD, S_MDIV, S_DONE
	} state_t;

	state_t                 state_q;
	logic                   op_q;
	logic [WIDTH_W-1:0]     wsh_q;
	logic [WREM_W-1:0]      wrem_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [DIST_W-1:0]      x_q;
	logic [DIST_W-1:0]      dvs_q;
	logic [REM_W-1:0]       rem_q;
	logic [PCT_W-1:0]       quot_q;
	logic [STEP_W-1:0]      step_q;
	logic [PCT_W-1:0]       pct_q;
	logic [PCT_W-1:0]       mean_q;
	logic [SUM_W-1:0]       sum_q;
	logic [IDX_W-1:0]       wi_q;
	logic [IDX_W-1:0]       fill_q;
	logic [NUM_SAMPLES-1:0] valid_q;
	logic [PCT_W-1:0]       rd_q;
	logic [DIST_W-1:0]      full_q;
	logic [DIST_W-1:0]      empty_q;
	logic                   out_valid_q;
	logic [PCT_W-1:0]       smoothed_q;
	logic [PCT_W-1:0]       instant_q;

	logic [PCT_W-1:0] ring_mem [NUM_SAMPLES];

	// handshake outputs
	assign in_ready         = (state_q == S_IDLE);
	assign cfg_ready        = 1'b1;
	assign out_valid        = out_valid_q;
	assign smoothed_percent = smoothed_q;
	assign instant_percent  = instant_q;

	// one step of the divide by 58, dividend bits leave the top of wsh_q
	logic [WREM_W:0] w_trial;
	logic            w_ge;
	logic [WREM_W:0] w_diff;
	assign w_trial = {wrem_q, wsh_q[WIDTH_W-1]};
	assign w_ge    = (w_trial >= (WREM_W+1)'(ECHO_DIV));
	assign w_diff  = w_trial - (WREM_W+1)'(ECHO_DIV);

	// clamp of the distance into full..empty
	logic [WIDTH_W-1:0] lo_e;
	logic [WIDTH_W-1:0] hi_e;
	logic [WIDTH_W-1:0] d_clamp;
	logic               d_below;
	assign lo_e    = WIDTH_W'(full_q);
	assign hi_e    = WIDTH_W'(empty_q);
	assign d_below = (wsh_q < lo_e);
	always_comb begin
		if (d_below) begin
			d_clamp = lo_e;
		end else if (wsh_q > hi_e) begin
			d_clamp = hi_e;
		end else begin
			d_clamp = wsh_q;
		end
	end

	// scaled numerator, offset times 100
	logic [NUM_W-1:0] num;
	assign num = NUM_W'(x_q) * NUM_W'(PCT_FULL);

	// shared quotient step, one bit of a 7-bit quotient per cycle
	logic [REM_W-1:0] dvs_sh;
	logic             q_ge;
	logic [PCT_W-1:0] q_next;
	assign dvs_sh = REM_W'(dvs_q) << step_q;
	assign q_ge   = (rem_q >= dvs_sh);
	assign q_next = {quot_q[PCT_W-2:0], q_ge};

	// ring slot being replaced by a normal update
	logic [PCT_W-1:0] old_pct;
	assign old_pct = valid_q[wi_q] ? rd_q : '0;

	// ring memory write port
	logic             mem_we;
	logic [IDX_W-1:0] mem_addr;
	always_comb begin
		mem_we   = 1'b0;
		mem_addr = wi_q;
		if (state_q == S_RING && op_q == OP_NORMAL) begin
			mem_we = 1'b1;
		end else if (state_q == S_FILL) begin
			mem_we   = 1'b1;
			mem_addr = fill_q;
		end
	end

	// ring memory, registered read at the write index
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_addr] <= pct_q;
		end
		rd_q <= ring_mem[wi_q];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= FULL_RESET;
			empty_q <= EMPTY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FULL:  full_q  <= cfg_data;
				REG_EMPTY: empty_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wi_q        <= '0;
			valid_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			op_q        <= OP_NORMAL;
			cnt_q       <= '0;
			step_q      <= '0;
			fill_q      <= '0;
			wsh_q       <= '0;
			wrem_q      <= '0;
			x_q         <= '0;
			dvs_q       <= '0;
			rem_q       <= '0;
			quot_q      <= '0;
			pct_q       <= '0;
			mean_q      <= '0;
			smoothed_q  <= '0;
			instant_q   <= '0;
		end else begin
			// result taken, unless a new one is loaded below
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= operation;
						wsh_q   <= echo_width_us;
						wrem_q  <= '0;
						cnt_q   <= CNT_W'(WIDTH_W - 1);
						state_q <= S_DIST;
					end
				end
				S_DIST: begin
					wrem_q <= w_ge ? w_diff[WREM_W-1:0] : w_trial[WREM_W-1:0];
					wsh_q  <= {wsh_q[WIDTH_W-2:0], w_ge};
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					if (full_q == empty_q) begin
						pct_q   <= PCT_W'(PCT_FULL);
						state_q <= S_RING;
					end else if (full_q > empty_q) begin
						// reversed range: anything at or past full reads as empty
						pct_q   <= d_below ? PCT_W'(PCT_FULL) : '0;
						state_q <= S_RING;
					end else begin
						x_q     <= d_clamp[DIST_W-1:0] - full_q;
						dvs_q   <= empty_q - full_q;
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					rem_q   <= REM_W'(num);
					quot_q  <= '0;
					step_q  <= STEP_W'(PCT_W - 1);
					state_q <= S_PDIV;
				end
				S_PDIV: begin
					if (q_ge) begin
						rem_q <= rem_q - dvs_sh;
					end
					quot_q <= q_next;
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						pct_q   <= PCT_W'(PCT_FULL) - q_next;
						state_q <= S_RING;
					end
				end
				S_RING: begin
					if (op_q == OP_FAST) begin
						fill_q  <= '0;
						sum_q   <= '0;
						state_q <= S_FILL;
					end else begin
						sum_q          <= sum_q - SUM_W'(old_pct) + SUM_W'(pct_q);
						valid_q[wi_q]  <= 1'b1;
						wi_q           <= (wi_q == IDX_W'(NUM_SAMPLES - 1)) ? '0 : wi_q + 1'b1;
						state_q        <= S_MLOAD;
					end
				end
				S_FILL: begin
					valid_q[fill_q] <= 1'b1;
					sum_q           <= sum_q + SUM_W'(pct_q);
					fill_q          <= fill_q + 1'b1;
					if (fill_q == IDX_W'(NUM_SAMPLES - 1)) begin
						state_q <= S_MLOAD;
					end
				end
				S_MLOAD: begin
					rem_q   <= REM_W'(sum_q);
					dvs_q   <= DIST_W'(NUM_SAMPLES);
					quot_q  <= '0;
					step_q  <= STEP_W'(PCT_W - 1);
					state_q <= S_MDIV;
				end
				S_MDIV: begin
					if (q_ge) begin
						rem_q <= rem_q - dvs_sh;
					end
					quot_q <= q_next;
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						mean_q  <= q_next;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						smoothed_q  <= mean_q;
						instant_q   <= pct_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// write index stays inside the ring
	a_wi_range: assert property (@(posedge clk) disable iff (!arst_n)
		wi_q <= IDX_W'(NUM_SAMPLES - 1))
		else $error("write index outside ring");

	// running sum never exceeds a full ring of 100s
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MLOAD |-> sum_q <= SUM_W'(PCT_FULL * NUM_SAMPLES))
		else $error("ring sum out of range");

	// percentage settled before the ring update
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RING |-> pct_q <= PCT_W'(PCT_FULL))
		else $error("percentage above 100");

	// a result appears only from the final state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result loaded outside done state");

	// mean of percentages stays a percentage
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> smoothed_q <= PCT_W'(PCT_FULL))
		else $error("smoothed percentage above 100");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the echo level smoother. A queue-fed driver sends
// echo words, and a monitor checks every result word against a built-in
// level predictor. The ring and the distance registers are tracked alongside
// the block. Directed corner words come first, then random phases, each
// under its own pair of distance settings.
// ---------------------------------------------------------------------------

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import els_pkg::*;

	localparam int RING_DEPTH = NUM_SAMPLES_DEF;
	localparam int WIDTH_MAX  = (1 << WIDTH_W) - 1;
	localparam int SHOW_LIMIT = 10;
	localparam int QUIET_LO   = 40000;
	localparam int QUIET_HI   = 56000;

	typedef struct {
		logic               op;
		logic [WIDTH_W-1:0] width;
	} echo_word_t;

	typedef struct {
		logic [PCT_W-1:0] smoothed;
		logic [PCT_W-1:0] instant;
	} level_word_t;

	// clock, reset and block ports
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               operation = OP_NORMAL;
	logic [WIDTH_W-1:0] echo_width_us = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [PCT_W-1:0]   smoothed_percent;
	logic [PCT_W-1:0]   instant_percent;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FULL;
	logic [DIST_W-1:0]  cfg_data = '0;

	// stimulus and expectation stores
	echo_word_t  echo_words[$];
	level_word_t level_expect[$];

	// predictor state
	logic [DIST_W-1:0] full_cm  = FULL_RESET;
	logic [DIST_W-1:0] empty_cm = EMPTY_RESET;
	logic [PCT_W-1:0]  ring_pct [RING_DEPTH];
	int unsigned       ring_ptr = 0;

	int unsigned cycle_count = 0;
	int unsigned fail_count = 0;
	bit          in_took = 1'b0;

	echo_level_percent_smoother #(
		.NUM_SAMPLES(RING_DEPTH)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.echo_width_us    (echo_width_us),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.smoothed_percent (smoothed_percent),
		.instant_percent  (instant_percent),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// random idle, except in one quiet stretch
	function automatic bit idle_now();
		if (cycle_count >= QUIET_LO && cycle_count < QUIET_HI)
			return 1'b0;
		return $urandom_range(0, 99) < 18;
	endfunction

	// echo width to level percent under the current distance settings
	function automatic logic [PCT_W-1:0] level_from_width(logic [WIDTH_W-1:0] w);
		int dist_cm;
		int lo;
		int hi;
		int den;
		int pct;
		dist_cm = (int'(w) / US_PER_CM) / ROUND_TRIP;
		lo      = int'(full_cm);
		hi      = int'(empty_cm);
		if (dist_cm < lo)
			dist_cm = lo;
		else if (dist_cm > hi)
			dist_cm = hi;
		den = hi - lo;
		if (den == 0)
			return PCT_W'(PCT_FULL);
		pct = ((dist_cm - lo) * -PCT_FULL) / den + PCT_FULL;
		if (pct < 0)
			pct = 0;
		if (pct > PCT_FULL)
			pct = PCT_FULL;
		return PCT_W'(pct);
	endfunction

	// update the ring with one accepted word and queue its result
	function automatic void absorb_echo_word(logic op, logic [WIDTH_W-1:0] w);
		logic [PCT_W-1:0] pct;
		int unsigned      sum;
		level_word_t      res;
		pct = level_from_width(w);
		if (op == OP_FAST) begin
			for (int i = 0; i < RING_DEPTH; i++)
				ring_pct[i] = pct;
		end else begin
			ring_pct[ring_ptr] = pct;
			ring_ptr = (ring_ptr + 1) % RING_DEPTH;
		end
		sum = 0;
		for (int i = 0; i < RING_DEPTH; i++)
			sum += ring_pct[i];
		res.smoothed = PCT_W'(sum / RING_DEPTH);
		res.instant  = pct;
		level_expect.push_back(res);
	endfunction

	function automatic void note_failure(string what);
		fail_count++;
		if (fail_count <= SHOW_LIMIT)
			$display("[%0t] ERROR: %s", $realtime, what);
	endfunction

	// input driver: holds each word until accepted
	always @(negedge clk) begin
		echo_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (echo_words.size() > 0 && !idle_now()) begin
				w = echo_words.pop_front();
				in_valid      <= 1'b1;
				operation     <= w.op;
				echo_width_us <= w.width;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side backpressure
	always @(negedge clk) begin
		out_ready <= arst_n && !idle_now();
	end

	// monitor: config and input accepts feed the predictor, results are checked
	always @(posedge clk) begin
		level_word_t exp_w;
		cycle_count++;
		in_took = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FULL:  full_cm = cfg_data;
					REG_EMPTY: empty_cm = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				in_took = 1'b1;
				absorb_echo_word(operation, echo_width_us);
			end
			if (out_valid && out_ready) begin
				if (level_expect.size() == 0) begin
					note_failure($sformatf("result word with none expected: smoothed %0d instant %0d",
						smoothed_percent, instant_percent));
				end else begin
					exp_w = level_expect.pop_front();
					if (smoothed_percent !== exp_w.smoothed || instant_percent !== exp_w.instant)
						note_failure($sformatf(
							"level mismatch: smoothed exp %0d got %0d, instant exp %0d got %0d",
							exp_w.smoothed, smoothed_percent, exp_w.instant, instant_percent));
				end
			end
		end
	end

	task automatic push_word(logic op, int unsigned w);
		echo_word_t item;
		item.op    = op;
		item.width = WIDTH_W'(w);
		echo_words.push_back(item);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_distances(int unsigned full_v, int unsigned empty_v);
		write_reg(REG_FULL, DIST_W'(full_v));
		write_reg(REG_EMPTY, DIST_W'(empty_v));
	endtask

	// wait until every word is sent and every result is back
	task automatic drain();
		while (echo_words.size() > 0 || in_valid || level_expect.size() > 0)
			@(posedge clk);
	endtask

	// random word, mostly with distances around the configured window
	task automatic push_random_word();
		logic        op;
		int          lo_w;
		int          hi_w;
		int unsigned sel;
		op  = ($urandom_range(0, 9) == 0) ? OP_FAST : OP_NORMAL;
		sel = $urandom_range(0, 19);
		if (sel == 0) begin
			push_word(op, 0);
		end else if (sel <= 3) begin
			push_word(op, $urandom & WIDTH_MAX);
		end else begin
			lo_w = ((full_cm < empty_cm) ? int'(full_cm) : int'(empty_cm)) * 58 - 400;
			hi_w = ((full_cm < empty_cm) ? int'(empty_cm) : int'(full_cm)) * 58 + 457;
			if (lo_w < 0)
				lo_w = 0;
			if (lo_w > WIDTH_MAX)
				lo_w = WIDTH_MAX - 1000;
			if (hi_w > WIDTH_MAX)
				hi_w = WIDTH_MAX;
			push_word(op, $urandom_range(hi_w, lo_w));
		end
	endtask

	task automatic pick_random_distances();
		int unsigned f;
		int unsigned e;
		case ($urandom_range(0, 7))
			0: begin
				f = $urandom_range(0, 9000);
				e = f;
			end
			1: begin
				f = $urandom & 16'hFFFF;
				e = $urandom & 16'hFFFF;
			end
			2: begin
				e = $urandom_range(0, 4000);
				f = e + $urandom_range(1, 4000);
			end
			default: begin
				f = $urandom_range(0, 3000);
				e = f + $urandom_range(1, 6000);
			end
		endcase
		set_distances(f, e);
	endtask

	initial begin
		for (int i = 0; i < RING_DEPTH; i++)
			ring_pct[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset distances, full beyond empty: timeout, widths above range
		push_word(OP_NORMAL, 0);
		push_word(OP_NORMAL, WIDTH_MAX);
		push_word(OP_NORMAL, 500000);
		push_word(OP_FAST, 500001);
		push_word(OP_NORMAL, 255 * 58 - 1);
		push_word(OP_NORMAL, 255 * 58);
		drain();

		// ordinary window, edges and just outside
		set_distances(20, 300);
		push_word(OP_NORMAL, 20 * 58);
		push_word(OP_NORMAL, 300 * 58);
		push_word(OP_NORMAL, 160 * 58);
		push_word(OP_NORMAL, 19 * 58);
		push_word(OP_NORMAL, 302 * 58);
		push_word(OP_FAST, 5000);
		push_word(OP_NORMAL, 0);
		push_word(OP_NORMAL, 160 * 58);
		push_word(OP_NORMAL, WIDTH_MAX);
		drain();

		// equal distances
		set_distances(100, 100);
		push_word(OP_NORMAL, 100 * 58);
		push_word(OP_NORMAL, 0);
		push_word(OP_FAST, WIDTH_MAX);
		drain();

		// register extremes
		set_distances(0, 16'hFFFF);
		push_word(OP_NORMAL, 0);
		push_word(OP_NORMAL, WIDTH_MAX);
		push_word(OP_FAST, 262144);
		drain();
		set_distances(16'hFFFF, 0);
		push_word(OP_NORMAL, WIDTH_MAX);
		push_word(OP_NORMAL, 0);
		drain();
		set_distances(16'hFFFF, 16'hFFFF);
		push_word(OP_NORMAL, 1);
		drain();

		// random phases
		for (int p = 0; p < 10; p++) begin
			pick_random_distances();
			for (int n = 0; n < 195; n++)
				push_random_word();
			drain();
		end

		repeat (60) @(posedge clk);
		if (fail_count == 0 && level_expect.size() == 0)
			$display("echo_level_percent_smoother test passed");
		else
			$display("echo_level_percent_smoother test failed");
		$finish;
	end

	// run limit
	initial begin
		#4000000;
		$display("echo_level_percent_smoother test failed");
		$finish;
	end

endmodule
